// ===== rtl/sliding_window_mean_core_assert.svh =====
// ---------------------------------------------------------------------------
// sliding window mean assertion macros
// concurrent check wrappers, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEAN_CORE_ASSERT_SVH
`define SLIDING_WINDOW_MEAN_CORE_ASSERT_SVH

`ifndef SYNTH

// property holds on every clock edge outside reset
`define SWM_ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sliding window mean: invariant violated");

// antecedent implies consequent in the following cycle
`define SWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sliding window mean: sequence violated");

`else

`define SWM_ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define SWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/swm_pkg.sv =====
// ---------------------------------------------------------------------------
// swm_pkg
// shared types and defaults for the sliding window mean core
// ---------------------------------------------------------------------------
package swm_pkg;

    localparam int DEFAULT_WINDOW = 16;
    localparam int SAMPLE_W       = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SUB,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// ===== rtl/sliding_window_mean_core.sv =====
// ---------------------------------------------------------------------------
// sliding_window_mean_core
// running mean of the last WINDOW unsigned 16.16 samples, truncated quotient
// ---------------------------------------------------------------------------
//
//  channel   | valid           | stall           | payload
//  ----------+-----------------+-----------------+-------------------------
//  sample in | i_sample_valid  | o_sample_stall  | i_sample_value  [31:0]
//  mean out  | o_mean_valid    | i_mean_stall    | o_window_mean   [31:0]
//
//  a beat steps IDLE, ADD, DIV, DONE while the ring is filling and adds SUB
//  after ADD once full (TW = 32 + clog2(WINDOW) quotient bits); the
//  restoring divider runs one quotient bit a cycle on the shared add/sub unit
//  the finished mean sits in an output register, so the next sample is taken
//  while it waits; a stalled output holds the divider in its last state
//  reset clears total, fill count, ring pointer and output valid; the ring
//  itself is not cleared
//
module sliding_window_mean_core #(
    parameter int WINDOW = swm_pkg::DEFAULT_WINDOW
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_sample_valid,
    output logic        o_sample_stall,
    input  logic [31:0] i_sample_value,
    output logic        o_mean_valid,
    input  logic        i_mean_stall,
    output logic [31:0] o_window_mean
);

    localparam int CW = $clog2(WINDOW);
    localparam int TW = swm_pkg::SAMPLE_W + CW;
    localparam int FW = $clog2(WINDOW + 1);
    localparam int SW = (CW > 0) ? CW : 1;
    localparam int NW = $clog2(TW + 1);
    localparam int AW = TW + 1;

    swm_pkg::t_state r_state, n_state;

    logic [31:0]   r_ring [WINDOW];
    logic [31:0]   r_sample;
    logic [31:0]   r_old;
    logic          r_full;
    logic [TW-1:0] r_total;
    logic [FW-1:0] r_fill;
    logic [SW-1:0] r_slot;
    logic [FW-1:0] r_rem;
    logic [TW-1:0] r_quo;
    logic [NW-1:0] r_cnt;
    logic          r_mean_valid;
    logic [31:0]   r_mean;

    logic          in_acc;
    logic          out_load;
    logic          div_last;
    logic          div_fit;
    logic [FW:0]   rem_sh;
    logic [AW-1:0] alu_a;
    logic [AW-1:0] alu_b;
    logic          alu_sub;
    logic [AW-1:0] alu_res;

    // shared add/sub unit
    assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    assign rem_sh   = {r_rem, r_quo[TW-1]};
    assign div_fit  = !alu_res[AW-1];
    assign div_last = (r_cnt == NW'(TW - 1));
    assign in_acc   = i_sample_valid && !o_sample_stall;
    assign out_load = (r_state == swm_pkg::S_DONE) && (!r_mean_valid || !i_mean_stall);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swm_pkg::S_IDLE: begin
                if (i_sample_valid) begin
                    n_state = swm_pkg::S_ADD;
                end
            end
            swm_pkg::S_ADD: begin
                n_state = r_full ? swm_pkg::S_SUB : swm_pkg::S_DIV;
            end
            swm_pkg::S_SUB: begin
                n_state = swm_pkg::S_DIV;
            end
            swm_pkg::S_DIV: begin
                if (div_last) begin
                    n_state = swm_pkg::S_DONE;
                end
            end
            swm_pkg::S_DONE: begin
                if (!r_mean_valid || !i_mean_stall) begin
                    n_state = swm_pkg::S_IDLE;
                end
            end
            default: n_state = swm_pkg::S_IDLE;
        endcase
    end

    // outputs and unit operand select
    always_comb begin
        o_sample_stall = 1'b1;
        alu_a          = '0;
        alu_b          = '0;
        alu_sub        = 1'b0;
        unique case (r_state)
            swm_pkg::S_IDLE: begin
                o_sample_stall = 1'b0;
            end
            swm_pkg::S_ADD: begin
                alu_a = {1'b0, r_total};
                alu_b = AW'(r_sample);
            end
            swm_pkg::S_SUB: begin
                alu_a   = {1'b0, r_total};
                alu_b   = AW'(r_old);
                alu_sub = 1'b1;
            end
            swm_pkg::S_DIV: begin
                alu_a   = AW'(rem_sh);
                alu_b   = AW'(r_fill);
                alu_sub = 1'b1;
            end
            swm_pkg::S_DONE: begin
                o_sample_stall = 1'b1;
            end
            default: o_sample_stall = 1'b1;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= swm_pkg::S_IDLE;
            r_full       <= 1'b0;
            r_total      <= '0;
            r_fill       <= '0;
            r_slot       <= '0;
            r_cnt        <= '0;
            r_mean_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_full <= (r_fill == FW'(WINDOW));
                r_slot <= (r_slot == SW'(WINDOW - 1)) ? '0 : r_slot + SW'(1);
            end
            if (r_state == swm_pkg::S_ADD) begin
                r_total <= alu_res[TW-1:0];
                r_cnt   <= '0;
                if (!r_full) begin
                    r_fill <= r_fill + FW'(1);
                end
            end
            if (r_state == swm_pkg::S_SUB) begin
                r_total <= alu_res[TW-1:0];
            end
            if (r_state == swm_pkg::S_DIV) begin
                r_cnt <= r_cnt + NW'(1);
            end
            if (out_load) begin
                r_mean_valid <= 1'b1;
            end else if (!i_mean_stall) begin
                r_mean_valid <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample       <= i_sample_value;
            r_old          <= r_ring[r_slot];
            r_ring[r_slot] <= i_sample_value;
        end
        // dividend loads from the updated total
        if ((r_state == swm_pkg::S_ADD && !r_full) || r_state == swm_pkg::S_SUB) begin
            r_quo <= alu_res[TW-1:0];
            r_rem <= '0;
        end
        if (r_state == swm_pkg::S_DIV) begin
            r_rem <= div_fit ? alu_res[FW-1:0] : rem_sh[FW-1:0];
            r_quo <= {r_quo[TW-2:0], div_fit};
        end
        if (out_load) begin
            r_mean <= r_quo[31:0];
        end
    end

    assign o_mean_valid  = r_mean_valid;
    assign o_window_mean = r_mean;

    `include "sliding_window_mean_core_assert.svh"

    `SWM_ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, r_fill <= FW'(WINDOW))
    `SWM_ASSERT_ALWAYS(a_slot_bound, i_clk, i_rst_n, 32'(r_slot) < 32'(WINDOW))
    `SWM_ASSERT_ALWAYS(a_div_nonzero, i_clk, i_rst_n, (r_state != swm_pkg::S_DIV) || (r_fill != '0))
    `SWM_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, in_acc, r_state == swm_pkg::S_ADD)
    `SWM_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, out_load, o_mean_valid && (r_state == swm_pkg::S_IDLE))

endmodule
